// ----- rtl/ptstc_pkg.sv -----
package ptstc_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 360;

    localparam int AREA_W   = 26;
    localparam int MOM_W    = 36;
    localparam int ANGLE_W  = 10;
    localparam int BAND_W   = 9;
    localparam int STEP_W   = 5;
    localparam int MISS_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 26;

    // Wide enough for frame centre plus the largest dead band
    localparam int CMP_W = 13;
    localparam int SUM_W = ANGLE_W + 2;

    localparam int SCAN_PAN_STEP  = 6;
    localparam int SCAN_TILT_STEP = 12;
    localparam int ANGLE_MIN = -512;
    localparam int ANGLE_MAX = 511;
    localparam int MISS_MAX  = 63;

    localparam int CENTER_X = FRAME_WIDTH / 2;
    localparam int CENTER_Y = FRAME_HEIGHT / 2;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AREA_THRESHOLD = 3'd0,
        REG_DEAD_BAND      = 3'd1,
        REG_TRACK_STEP     = 3'd2,
        REG_LOST_LIMIT     = 3'd3,
        REG_PAN_MIN        = 3'd4,
        REG_PAN_MAX        = 3'd5,
        REG_TILT_MIN       = 3'd6,
        REG_TILT_MAX       = 3'd7
    } cfg_index_t;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [SUM_W-1:0]   angle_sum_t;

    // Divider control toward the serial unit and status back
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

    function automatic angle_t sat_angle(input angle_sum_t v);
        angle_t r;
        if (v < angle_sum_t'(ANGLE_MIN))
            r = angle_t'(ANGLE_MIN);
        else if (v > angle_sum_t'(ANGLE_MAX))
            r = angle_t'(ANGLE_MAX);
        else
            r = v[ANGLE_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/ptstc_div.sv -----
module ptstc_div
    import ptstc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_ctrl_t             ctrl,
    input  logic [MOM_W-1:0]      dividend,
    input  logic [AREA_W-1:0]     divisor,
    output div_stat_t             stat,
    output logic [MOM_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(MOM_W + 1);

    logic [MOM_W-1:0]  quo_reg, quo_next;
    logic [AREA_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [AREA_W:0]   trial;
    logic [AREA_W:0]   diff;

    // One quotient bit per cycle while busy: shift the next dividend bit into the remainder
    assign trial = {rem_reg, quo_reg[MOM_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(MOM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[AREA_W-1:0];
                quo_next = {quo_reg[MOM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[AREA_W-1:0];
                quo_next = {quo_reg[MOM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- rtl/pan_tilt_scan_track_controller_top.sv -----
// A frame whose area does not exceed the threshold goes from the scan state straight to the
// finish state; one above it runs two 36-step bit-serial divisions in turn (x, then y) on
// the single shared serial divider, so only one frame is handled at a time.
// A new input is taken once the previous result sits in the output register.
// Reset (rst_n, asynchronous, active low) restores register defaults and the
// home pose (pan 90, tilt 90, scanning upward, not tracking, miss count 0).
module pan_tilt_scan_track_controller_top
    import ptstc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // area_sum [25:0], x_moment [61:26], y_moment [97:62], zero fill [103:98]
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pan_angle [9:0], tilt_angle [19:10], object_found [20], is_tracking [21],
    // zero fill [23:22]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DAT_W-1:0]   cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_DIVX = 5'b00100,
        ST_DIVY = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [AREA_W-1:0] thr_reg;
    logic [BAND_W-1:0] band_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] limit_reg;
    angle_t            pan_min_reg, pan_max_reg, tilt_min_reg, tilt_max_reg;

    // Controller state
    angle_t            pan_reg, pan_next;
    angle_t            tilt_reg, tilt_next;
    logic              pan_up_reg, pan_up_next;
    logic              tilt_up_reg, tilt_up_next;
    logic              track_reg, track_next;
    logic [MISS_W-1:0] miss_reg, miss_next;
    logic              found_reg, found_next;

    // Latched frame moments
    logic [AREA_W-1:0] area_reg;
    logic [MOM_W-1:0]  xm_reg;
    logic [MOM_W-1:0]  ym_reg;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Divider
    div_ctrl_t        div_ctrl;
    div_stat_t        div_stat;
    logic [MOM_W-1:0] div_dividend;
    logic [MOM_W-1:0] quo;

    ptstc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (area_reg),
        .stat     (div_stat),
        .quotient (quo)
    );

    // Scan step
    angle_sum_t tstep;
    angle_t     scan_pan;
    angle_t     scan_tilt1, scan_tilt2;
    logic       pan_over, pan_under;
    logic       scan_pan_up, scan_tilt_up;

    always_comb
    begin
        tstep = tilt_up_reg ? angle_sum_t'(SCAN_TILT_STEP) : -angle_sum_t'(SCAN_TILT_STEP);
        scan_pan = sat_angle(angle_sum_t'(pan_reg) + (pan_up_reg ? angle_sum_t'(SCAN_PAN_STEP)
                                                                 : -angle_sum_t'(SCAN_PAN_STEP)));
        pan_over  = scan_pan > pan_max_reg;
        pan_under = scan_pan < pan_min_reg;
        scan_pan_up = pan_up_reg;
        scan_tilt1  = tilt_reg;
        if (pan_over)
        begin
            scan_pan_up = 1'b0;
            scan_tilt1  = sat_angle(angle_sum_t'(tilt_reg) + tstep);
        end
        scan_tilt2 = scan_tilt1;
        if (pan_under)
        begin
            scan_pan_up = 1'b1;
            scan_tilt2  = sat_angle(angle_sum_t'(scan_tilt1) + tstep);
        end
        scan_tilt_up = tilt_up_reg;
        if (scan_tilt2 > tilt_max_reg)
            scan_tilt_up = 1'b0;
        if (scan_tilt2 < tilt_min_reg)
            scan_tilt_up = 1'b1;
    end

    // Centroid against frame centre plus or minus the dead band
    logic signed [CMP_W:0] lo_x, lo_y;
    logic [CMP_W-1:0]      hi_x, hi_y;
    logic                  quo_high;
    logic                  below_x, above_x, below_y, above_y;
    angle_sum_t            tstep_trk;
    angle_t                pan_nudged, tilt_nudged;

    always_comb
    begin
        lo_x = (CMP_W+1)'(CENTER_X) - $signed({{(CMP_W+1-BAND_W){1'b0}}, band_reg});
        lo_y = (CMP_W+1)'(CENTER_Y) - $signed({{(CMP_W+1-BAND_W){1'b0}}, band_reg});
        hi_x = CMP_W'(CENTER_X) + CMP_W'(band_reg);
        hi_y = CMP_W'(CENTER_Y) + CMP_W'(band_reg);
        quo_high = |quo[MOM_W-1:CMP_W];
        below_x = !quo_high && (lo_x > 0) && (quo[CMP_W-1:0] < lo_x[CMP_W-1:0]);
        above_x = quo_high || (quo[CMP_W-1:0] > hi_x);
        below_y = !quo_high && (lo_y > 0) && (quo[CMP_W-1:0] < lo_y[CMP_W-1:0]);
        above_y = quo_high || (quo[CMP_W-1:0] > hi_y);
        tstep_trk = angle_sum_t'(step_reg);
        // Pan follows x offset; tilt moves against y offset
        pan_nudged = pan_reg;
        if (below_x)
            pan_nudged = sat_angle(angle_sum_t'(pan_reg) - tstep_trk);
        else if (above_x)
            pan_nudged = sat_angle(angle_sum_t'(pan_reg) + tstep_trk);
        tilt_nudged = tilt_reg;
        if (above_y)
            tilt_nudged = sat_angle(angle_sum_t'(tilt_reg) - tstep_trk);
        else if (below_y)
            tilt_nudged = sat_angle(angle_sum_t'(tilt_reg) + tstep_trk);
    end

    logic              in_fire;
    logic              out_free;
    logic [MISS_W-1:0] miss_inc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign miss_inc = (miss_reg < MISS_W'(MISS_MAX)) ? miss_reg + MISS_W'(1) : miss_reg;

    always_comb
    begin
        state_next     = state_reg;
        pan_next       = pan_reg;
        tilt_next      = tilt_reg;
        pan_up_next    = pan_up_reg;
        tilt_up_next   = tilt_up_reg;
        track_next     = track_reg;
        miss_next      = miss_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        div_ctrl.start = 1'b0;
        div_dividend   = xm_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!track_reg)
                begin
                    pan_next     = scan_pan;
                    tilt_next    = scan_tilt2;
                    pan_up_next  = scan_pan_up;
                    tilt_up_next = scan_tilt_up;
                end
                found_next = area_reg > thr_reg;
                if (area_reg > thr_reg)
                begin
                    track_next     = 1'b1;
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIVX;
                end
                else
                begin
                    miss_next = miss_inc;
                    if (miss_inc > MISS_W'(limit_reg))
                    begin
                        track_next = 1'b0;
                        miss_next  = '0;
                    end
                    state_next = ST_FIN;
                end
            end
            ST_DIVX:
            begin
                if (div_stat.done)
                begin
                    pan_next       = pan_nudged;
                    div_dividend   = ym_reg;
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_stat.done)
                begin
                    tilt_next  = tilt_nudged;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pan_reg       <= angle_t'(90);
            tilt_reg      <= angle_t'(90);
            pan_up_reg    <= 1'b1;
            tilt_up_reg   <= 1'b1;
            track_reg     <= 1'b0;
            miss_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg       <= AREA_W'(10000);
            band_reg      <= BAND_W'(20);
            step_reg      <= STEP_W'(1);
            limit_reg     <= STEP_W'(10);
            pan_min_reg   <= angle_t'(0);
            pan_max_reg   <= angle_t'(180);
            tilt_min_reg  <= angle_t'(75);
            tilt_max_reg  <= angle_t'(125);
        end
        else
        begin
            state_reg     <= state_next;
            pan_reg       <= pan_next;
            tilt_reg      <= tilt_next;
            pan_up_reg    <= pan_up_next;
            tilt_up_reg   <= tilt_up_next;
            track_reg     <= track_next;
            miss_reg      <= miss_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_addr))
                    REG_AREA_THRESHOLD: thr_reg      <= cfg_data[AREA_W-1:0];
                    REG_DEAD_BAND:      band_reg     <= cfg_data[BAND_W-1:0];
                    REG_TRACK_STEP:     step_reg     <= cfg_data[STEP_W-1:0];
                    REG_LOST_LIMIT:     limit_reg    <= cfg_data[STEP_W-1:0];
                    REG_PAN_MIN:        pan_min_reg  <= cfg_data[ANGLE_W-1:0];
                    REG_PAN_MAX:        pan_max_reg  <= cfg_data[ANGLE_W-1:0];
                    REG_TILT_MIN:       tilt_min_reg <= cfg_data[ANGLE_W-1:0];
                    REG_TILT_MAX:       tilt_max_reg <= cfg_data[ANGLE_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            area_reg <= s_axis_tdata[AREA_W-1:0];
            xm_reg   <= s_axis_tdata[AREA_W+MOM_W-1:AREA_W];
            ym_reg   <= s_axis_tdata[AREA_W+2*MOM_W-1:AREA_W+MOM_W];
        end
        if (state_reg == ST_FIN && out_free)
            out_data_reg <= {2'b00, track_reg, found_reg, tilt_reg, pan_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- verif/tb_pan_tilt_scan_track_controller_top.sv -----
`timescale 1ns / 100ps

module tb_pan_tilt_scan_track_controller_top;
    import ptstc_pkg::*;

    localparam int FILL_W = IN_DATA_W - AREA_W - 2 * MOM_W;
    localparam int unsigned AREA_TOP = (1 << AREA_W) - 1;
    localparam logic [MOM_W-1:0] MOM_TOP = {MOM_W{1'b1}};
    localparam longint unsigned PROBE_AREA = 10001;
    localparam int N_PROBES = 23;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 240;

    typedef struct packed {
        angle_t pan;
        angle_t tilt;
        logic   found;
        logic   tracking;
    } servo_cmd_t;

    // area, x moment, y moment, typed flag, typed servo command
    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [MOM_W-1:0]  xm;
        logic [MOM_W-1:0]  ym;
        logic              typed;
        servo_cmd_t        want;
    } frame_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;

    // predictor copy of registers and pose
    logic [AREA_W-1:0] area_thr_q;
    logic [BAND_W-1:0] band_q;
    logic [STEP_W-1:0] step_q;
    logic [STEP_W-1:0] lost_q;
    angle_t            pan_lo_q, pan_hi_q, tilt_lo_q, tilt_hi_q;
    angle_t            pan_q, tilt_q;
    logic              pan_up, tilt_up, tracking_q;
    logic [MISS_W-1:0] miss_q;

    servo_cmd_t servo_expect_q[$];
    int         bad = 0;
    int         idle_pct = 37;

    pan_tilt_scan_track_controller_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    function automatic angle_t clamp_servo(input int v);
        angle_t r;
        if (v < ANGLE_MIN)
            r = angle_t'(ANGLE_MIN);
        else if (v > ANGLE_MAX)
            r = angle_t'(ANGLE_MAX);
        else
            r = angle_t'(v);
        return r;
    endfunction

    function automatic angle_t steer(input angle_t a, input longint off);
        angle_t r;
        r = a;
        if (off < -longint'(band_q))
            r = clamp_servo(int'(r) - int'(step_q));
        if (off > longint'(band_q))
            r = clamp_servo(int'(r) + int'(step_q));
        return r;
    endfunction

    // One frame of the scan/track loop on the predictor state
    function automatic servo_cmd_t advance_servo(input logic [AREA_W-1:0] area,
                                                 input logic [MOM_W-1:0] xm,
                                                 input logic [MOM_W-1:0] ym);
        int              tilt_delta;
        longint unsigned aw, cx, cy;
        logic            found;
        servo_cmd_t      r;
        if (!tracking_q)
        begin
            // tilt direction is taken before either pan bound fires
            tilt_delta = tilt_up ? SCAN_TILT_STEP : -SCAN_TILT_STEP;
            pan_q = clamp_servo(int'(pan_q) + (pan_up ? SCAN_PAN_STEP : -SCAN_PAN_STEP));
            if (pan_q > pan_hi_q)
            begin
                pan_up = 1'b0;
                tilt_q = clamp_servo(int'(tilt_q) + tilt_delta);
            end
            if (pan_q < pan_lo_q)
            begin
                pan_up = 1'b1;
                tilt_q = clamp_servo(int'(tilt_q) + tilt_delta);
            end
            if (tilt_q > tilt_hi_q)
                tilt_up = 1'b0;
            if (tilt_q < tilt_lo_q)
                tilt_up = 1'b1;
        end
        found = (area > area_thr_q);
        if (found)
        begin
            aw = area;
            cx = longint'(xm) / aw;
            cy = longint'(ym) / aw;
            tracking_q = 1'b1;
            pan_q = steer(pan_q, longint'(cx) - longint'(CENTER_X));
            tilt_q = steer(tilt_q, longint'(CENTER_Y) - longint'(cy));
        end
        else
        begin
            if (miss_q < MISS_MAX)
                miss_q = miss_q + 1'b1;
            if (miss_q > lost_q)
            begin
                tracking_q = 1'b0;
                miss_q = '0;
            end
        end
        r.pan = pan_q;
        r.tilt = tilt_q;
        r.found = found;
        r.tracking = tracking_q;
        return r;
    endfunction

    // Moment whose truncated centroid lands near the given centre in most draws, else at random
    function automatic logic [MOM_W-1:0] moment_near(input logic [AREA_W-1:0] area,
                                                     input int centre);
        longint          aim;
        longint unsigned aw, cap, c;
        aw = area;
        cap = ((64'd1 << MOM_W) - aw) / aw;
        if ($urandom_range(9) < 7)
            aim = longint'(centre) + longint'($urandom_range(2 * band_q + 6))
                  - longint'(band_q) - 3;
        else
            aim = longint'($urandom_range(8191));
        if (aim < 0)
            aim = 0;
        c = aim;
        if (c > cap)
            c = cap;
        return MOM_W'(c * aw + $urandom_range(area - 1));
    endfunction

    function automatic logic [CFG_DAT_W-1:0] angle_word(input angle_t a);
        return {{(CFG_DAT_W - ANGLE_W){1'b0}}, a};
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DAT_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_AREA_THRESHOLD: area_thr_q = val[AREA_W-1:0];
            REG_DEAD_BAND:      band_q     = val[BAND_W-1:0];
            REG_TRACK_STEP:     step_q     = val[STEP_W-1:0];
            REG_LOST_LIMIT:     lost_q     = val[STEP_W-1:0];
            REG_PAN_MIN:        pan_lo_q   = angle_t'(val[ANGLE_W-1:0]);
            REG_PAN_MAX:        pan_hi_q   = angle_t'(val[ANGLE_W-1:0]);
            REG_TILT_MIN:       tilt_lo_q  = angle_t'(val[ANGLE_W-1:0]);
            REG_TILT_MAX:       tilt_hi_q  = angle_t'(val[ANGLE_W-1:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_frame(input logic [AREA_W-1:0] area, input logic [MOM_W-1:0] xm,
                              input logic [MOM_W-1:0] ym, input logic typed,
                              input servo_cmd_t typed_cmd);
        servo_cmd_t predicted;
        servo_cmd_t queued;
        // drop valid only when a gap follows, so it never toggles within one step
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{FILL_W{1'b0}}, ym, xm, area};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = advance_servo(area, xm, ym);
        queued = typed ? typed_cmd : predicted;
        servo_expect_q = {servo_expect_q, queued};
    endtask

    // Runs of hits and misses so tracking is gained, held and lost
    task automatic send_random_frames(input int count);
        int                sent;
        int                run_len;
        int                pick;
        int unsigned       span;
        logic              hit_run;
        logic [AREA_W-1:0] area;
        logic [MOM_W-1:0]  xm, ym;
        sent = 0;
        while (sent < count)
        begin
            hit_run = ($urandom_range(99) < 55);
            run_len = $urandom_range(40, 1);
            for (int k = 0; k < run_len && sent < count; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    area = AREA_W'($urandom);
                    xm = MOM_W'({$urandom, $urandom});
                    ym = MOM_W'({$urandom, $urandom});
                end
                else if (hit_run && area_thr_q != AREA_TOP)
                begin
                    if (pick < 25)
                        area = AREA_W'($urandom_range(AREA_TOP, area_thr_q + 1));
                    else
                    begin
                        span = AREA_TOP - area_thr_q - 1;
                        area = AREA_W'(area_thr_q + 1 +
                                       $urandom_range((span < 400) ? span : 400));
                    end
                    xm = moment_near(area, CENTER_X);
                    ym = moment_near(area, CENTER_Y);
                end
                else
                begin
                    case ($urandom_range(3))
                        0: area = area_thr_q;
                        1: area = '0;
                        default: area = AREA_W'($urandom_range(area_thr_q));
                    endcase
                    xm = pick[0] ? MOM_W'({$urandom, $urandom}) : MOM_W'($urandom_range(500000));
                    ym = pick[1] ? MOM_W'({$urandom, $urandom}) : MOM_W'($urandom_range(500000));
                end
                send_frame(area, xm, ym, 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        servo_cmd_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tdata[20], m_axis_tdata[21]};
            if (servo_expect_q.size() == 0)
            begin
                bad++;
                if (bad <= 10)
                    $display("unexpected result: pan %0d tilt %0d found %0b tracking %0b",
                             got.pan, got.tilt, got.found, got.tracking);
            end
            else
            begin
                want = servo_expect_q.pop_front();
                if (got.pan !== want.pan || got.tilt !== want.tilt ||
                    got.found !== want.found || got.tracking !== want.tracking)
                begin
                    bad++;
                    if (bad <= 10)
                        $display("mismatch: pan %0d/%0d tilt %0d/%0d found %0b/%0b %s %0b/%0b",
                                 want.pan, got.pan, want.tilt, got.tilt,
                                 want.found, got.found, "tracking",
                                 want.tracking, got.tracking);
                end
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("pan_tilt_scan_track_controller_top regression: fail");
        $finish;
    end

    initial
    begin
        frame_row_t            probe_rows [N_PROBES];
        logic [CFG_DAT_W-1:0]  phase_regs [8];
        logic [AREA_W-1:0]     thr;
        logic [BAND_W-1:0]     band;
        logic [STEP_W-1:0]     step, lost;
        angle_t                plo, phi, tlo, thi, tmp;
        int                    drain;

        area_thr_q = 10000;
        band_q     = 20;
        step_q     = 1;
        lost_q     = 10;
        pan_lo_q   = 0;
        pan_hi_q   = 180;
        tilt_lo_q  = 75;
        tilt_hi_q  = 125;
        pan_q      = 90;
        tilt_q     = 90;
        pan_up     = 1'b1;
        tilt_up    = 1'b1;
        tracking_q = 1'b0;
        miss_q     = '0;

        // first scan step from home, then full-scale and zero moments
        probe_rows[0] = {26'd0, 36'd0, 36'd0, 1'b1, 10'sd96, 10'sd90, 1'b0, 1'b0};
        probe_rows[1] = {AREA_W'(AREA_TOP), MOM_TOP, MOM_TOP, 1'b1,
                         10'sd103, 10'sd89, 1'b1, 1'b1};
        probe_rows[2] = {AREA_W'(AREA_TOP), 36'd0, 36'd0, 1'b1,
                         10'sd102, 10'sd90, 1'b1, 1'b1};
        // centroid on centre and on either side of the dead band edges
        probe_rows[3] = {AREA_W'(PROBE_AREA), 36'(64'd320 * PROBE_AREA + PROBE_AREA - 1),
                         36'(64'd180 * PROBE_AREA + PROBE_AREA - 1), 1'b0, 22'd0};
        probe_rows[4] = {AREA_W'(PROBE_AREA), 36'(64'd340 * PROBE_AREA + PROBE_AREA - 1),
                         36'(64'd180 * PROBE_AREA), 1'b0, 22'd0};
        probe_rows[5] = {AREA_W'(PROBE_AREA), 36'(64'd341 * PROBE_AREA),
                         36'(64'd160 * PROBE_AREA + PROBE_AREA - 1), 1'b0, 22'd0};
        probe_rows[6] = {AREA_W'(PROBE_AREA), 36'(64'd300 * PROBE_AREA),
                         36'(64'd159 * PROBE_AREA + 7), 1'b0, 22'd0};
        probe_rows[7] = {AREA_W'(PROBE_AREA), 36'(64'd299 * PROBE_AREA + PROBE_AREA - 1),
                         36'(64'd200 * PROBE_AREA), 1'b0, 22'd0};
        probe_rows[8] = {AREA_W'(PROBE_AREA), 36'(64'd320 * PROBE_AREA),
                         36'(64'd201 * PROBE_AREA + 3), 1'b0, 22'd0};
        // area equal to the threshold is a miss
        probe_rows[9] = {26'd10000, MOM_TOP, MOM_TOP, 1'b0, 22'd0};
        // centroid far outside the frame
        probe_rows[10] = {AREA_W'(PROBE_AREA), MOM_TOP, MOM_TOP, 1'b0, 22'd0};
        probe_rows[11] = {26'd1, MOM_TOP, 36'd0, 1'b0, 22'd0};
        // misses until tracking drops, then scan resumes
        for (int i = 12; i < N_PROBES; i++)
            probe_rows[i] = {26'd0, i[0] ? MOM_TOP : 36'd0, i[1] ? MOM_TOP : 36'd0,
                             1'b0, 22'd0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_PROBES; i++)
            send_frame(probe_rows[i].area, probe_rows[i].xm, probe_rows[i].ym,
                       probe_rows[i].typed, probe_rows[i].want);

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            s_axis_tvalid <= 1'b0;
            while (servo_expect_q.size() != 0)
                @(posedge clk);
            idle_pct = (phase == 4) ? 0 : 37;
            case (phase)
                0:
                begin
                    thr = 0; band = 0; step = 31; lost = 0;
                    plo = -512; phi = 511; tlo = -512; thi = 511;
                end
                1:
                begin
                    // nothing can be found; crossed bounds on both axes
                    thr = AREA_W'(AREA_TOP); band = 511; step = 0; lost = 31;
                    plo = 511; phi = -512; tlo = 511; thi = -512;
                end
                2:
                begin
                    thr = 10000; band = 20; step = 1; lost = 10;
                    plo = 0; phi = 180; tlo = 75; thi = 125;
                end
                default:
                begin
                    case ($urandom_range(2))
                        0: thr = AREA_W'($urandom_range(60000));
                        1: thr = AREA_W'($urandom);
                        default: thr = AREA_W'($urandom_range(255));
                    endcase
                    band = ($urandom_range(3) == 0) ? BAND_W'($urandom)
                                                    : BAND_W'($urandom_range(60));
                    step = STEP_W'($urandom);
                    lost = STEP_W'($urandom);
                    plo = angle_t'($urandom);
                    phi = angle_t'($urandom);
                    tlo = angle_t'($urandom);
                    thi = angle_t'($urandom);
                    // phase 3 keeps pan bounds crossed, the rest ordered
                    if ((phase == 3) ? (plo < phi) : (plo > phi))
                    begin
                        tmp = plo; plo = phi; phi = tmp;
                    end
                    if (tlo > thi)
                    begin
                        tmp = tlo; tlo = thi; thi = tmp;
                    end
                end
            endcase
            phase_regs[REG_AREA_THRESHOLD] = thr;
            phase_regs[REG_DEAD_BAND]      = band;
            phase_regs[REG_TRACK_STEP]     = step;
            phase_regs[REG_LOST_LIMIT]     = lost;
            phase_regs[REG_PAN_MIN]        = angle_word(plo);
            phase_regs[REG_PAN_MAX]        = angle_word(phi);
            phase_regs[REG_TILT_MIN]       = angle_word(tlo);
            phase_regs[REG_TILT_MAX]       = angle_word(thi);
            for (int r = 0; r < 8; r++)
                write_reg(cfg_index_t'(r), phase_regs[r]);
            cfg_we <= 1'b0;
            send_random_frames(PHASE_ITEMS);
        end

        s_axis_tvalid <= 1'b0;
        idle_pct = 37;
        drain = 0;
        while (servo_expect_q.size() != 0 && drain < 200000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (100) @(posedge clk);

        if (bad == 0 && servo_expect_q.size() == 0)
            $display("pan_tilt_scan_track_controller_top regression: pass");
        else
            $display("pan_tilt_scan_track_controller_top regression: fail");
        $finish;
    end

endmodule
